[hdl/pwfs_pkg.sv]
package pwfs_pkg;

  // Width of the segment tick counter.
  localparam int TICK_W = 8;
  // Config registers are eight bits wide.
  localparam int CFG_W = 8;
  localparam int CFG_NUM = 4;
  localparam int CFG_IDX_W = $clog2(CFG_NUM);
  localparam int FRAME_BITS = 32;
  localparam int BITS_W = $clog2(FRAME_BITS) + 1;
  // Common width for the clamp compare.
  localparam int CMP_W = (TICK_W > CFG_W) ? TICK_W : CFG_W;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BITS_W-1:0] bits_t;

  localparam tick_t TICK_MAX = '1;
  localparam bits_t BITS_FULL = BITS_W'(FRAME_BITS);

  // Register indexes.
  localparam cfg_idx_t REG_MARKER_HIGH = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_GAP_LOW = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_ZERO_HIGH = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_ONE_HIGH = CFG_IDX_W'(3);

  // Input function codes.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_START_HIGH = 3'd1,
    PH_START_GAP = 3'd2,
    PH_BIT_HIGH = 3'd3,
    PH_BIT_GAP = 3'd4,
    PH_END_HIGH = 3'd5
  } phase_t;

  typedef struct packed {
    cfg_word_t marker_high_ticks;
    cfg_word_t gap_low_ticks;
    cfg_word_t zero_high_ticks;
    cfg_word_t one_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic load_rejected;
    logic [31:0] frame_word;
  } res_t;

  // Zero acts as one tick; values past the counter range saturate.
  function automatic tick_t clamp_ticks(input cfg_word_t v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx == '0) return tick_t'(1);
    if (vx > CMP_W'(TICK_MAX)) return TICK_MAX;
    return tick_t'(vx);
  endfunction

endpackage

[hdl/pwfs_ifs.sv]
interface pwfs_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  modport source (output valid, func, first_byte, second_byte, third_byte, input ready);
  modport sink (input valid, func, first_byte, second_byte, third_byte, output ready);
endinterface

interface pwfs_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic load_rejected;
  logic [31:0] frame_word;

  modport source (output valid, line_level, busy_res, frame_done, load_rejected, frame_word,
                  input ready);
  modport sink (input valid, line_level, busy_res, frame_done, load_rejected, frame_word,
                output ready);
endinterface

[hdl/pulse_width_ir_frame_sender.sv]
// Pulse-width IR frame sender.
// item channel (sink): func=1 loads a frame from three bytes (checksum byte is
//   their XOR, low byte of the word); func=0 is one timing tick.
// result channel (source): one word per item with line level, busy, frame
//   done, load rejected and the current frame word.
// cfg port: cfg_we/cfg_index/cfg_data write the four tick-count registers
//   (start/end mark, gap, zero mark, one mark); write only while idle.
// Output: an accepted item's result is registered in the output buffer behind
//   any waiting result. Throughput: one item per cycle while the skid slot is
//   free; the single decrement-and-select frame update never limits the rate.
// Stall: a two-word output buffer (output register plus skid) lets one more
//   item in while a result waits; ready drops only once both are full.
// Reset (rst, synchronous): line low, idle, frame word zero, registers back
//   to 16/1/2/8 ticks, output buffer empty.
module pulse_width_ir_frame_sender (
  input  logic                clk,
  input  logic                rst,
  pwfs_in_if.sink             item,
  pwfs_out_if.source          result,
  input  logic                cfg_we,
  input  pwfs_pkg::cfg_idx_t  cfg_index,
  input  pwfs_pkg::cfg_word_t cfg_data
);

  pwfs_pkg::cfg_t cfg;
  pwfs_pkg::res_t res;
  logic room;
  logic accept;

  // an item is taken whenever the skid slot is free
  assign item.ready = room;
  assign accept = item.valid && room;

  pwfs_regs u_regs (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  // frame state machine plus result computation
  pwfs_core u_core (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .func(item.func),
    .first_byte(item.first_byte),
    .second_byte(item.second_byte),
    .third_byte(item.third_byte),
    .cfg(cfg),
    .res(res)
  );

  pwfs_obuf u_obuf (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .din(res),
    .room(room),
    .out(result)
  );

  // backpressure only when a result is already waiting
  a_ready_means_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid) else $error("ready low with empty output");

  // line is only driven high during a frame
  a_line_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.line_level |-> result.busy_res)
    else $error("line high while idle");

  // end of frame leaves the block idle with the line low
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_done |-> !result.busy_res && !result.line_level)
    else $error("frame done while busy");

  // a rejected load only happens mid-frame
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.load_rejected |-> result.busy_res)
    else $error("load rejected while idle");

endmodule

[hdl/pwfs_regs.sv]
module pwfs_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  pwfs_pkg::cfg_idx_t cfg_index,
  input  pwfs_pkg::cfg_word_t cfg_data,
  output pwfs_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_high_ticks <= pwfs_pkg::cfg_word_t'(16);
      cfg.gap_low_ticks <= pwfs_pkg::cfg_word_t'(1);
      cfg.zero_high_ticks <= pwfs_pkg::cfg_word_t'(2);
      cfg.one_high_ticks <= pwfs_pkg::cfg_word_t'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        pwfs_pkg::REG_MARKER_HIGH: cfg.marker_high_ticks <= cfg_data;
        pwfs_pkg::REG_GAP_LOW: cfg.gap_low_ticks <= cfg_data;
        pwfs_pkg::REG_ZERO_HIGH: cfg.zero_high_ticks <= cfg_data;
        pwfs_pkg::REG_ONE_HIGH: cfg.one_high_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/pwfs_core.sv]
module pwfs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           func,
  input  logic [7:0]     first_byte,
  input  logic [7:0]     second_byte,
  input  logic [7:0]     third_byte,
  input  pwfs_pkg::cfg_t cfg,
  output pwfs_pkg::res_t res
);

  pwfs_pkg::phase_t phase, phase_next;
  pwfs_pkg::tick_t ticks_left, ticks_left_next, ticks_dec;
  logic [31:0] shift_word, shift_word_next;
  logic [31:0] frame_copy, frame_copy_next;
  pwfs_pkg::bits_t bits_left, bits_left_next, bits_dec;
  logic line_reg, line_reg_next;
  logic done, rejected;
  pwfs_pkg::tick_t bit_ticks;

  assign ticks_dec = ticks_left - pwfs_pkg::tick_t'(1);
  assign bits_dec = bits_left - pwfs_pkg::bits_t'(1);

  always_comb begin
    phase_next = phase;
    ticks_left_next = ticks_left;
    shift_word_next = shift_word;
    frame_copy_next = frame_copy;
    bits_left_next = bits_left;
    line_reg_next = line_reg;
    done = 1'b0;
    rejected = 1'b0;
    bit_ticks = pwfs_pkg::clamp_ticks(shift_word[0] ? cfg.one_high_ticks : cfg.zero_high_ticks);
    if (func == pwfs_pkg::FUNC_LOAD) begin
      if (phase != pwfs_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        frame_copy_next = {first_byte, second_byte, third_byte,
                           first_byte ^ second_byte ^ third_byte};
        shift_word_next = frame_copy_next;
        bits_left_next = '0;
        phase_next = pwfs_pkg::PH_START_HIGH;
        line_reg_next = 1'b1;
        ticks_left_next = pwfs_pkg::clamp_ticks(cfg.marker_high_ticks);
      end
    end else if (phase != pwfs_pkg::PH_IDLE) begin
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        case (phase)
          pwfs_pkg::PH_START_HIGH: begin
            phase_next = pwfs_pkg::PH_START_GAP;
            line_reg_next = 1'b0;
            ticks_left_next = pwfs_pkg::clamp_ticks(cfg.gap_low_ticks);
          end
          pwfs_pkg::PH_START_GAP: begin
            bits_left_next = pwfs_pkg::BITS_FULL;
            phase_next = pwfs_pkg::PH_BIT_HIGH;
            line_reg_next = 1'b1;
            ticks_left_next = bit_ticks;
          end
          pwfs_pkg::PH_BIT_HIGH: begin
            phase_next = pwfs_pkg::PH_BIT_GAP;
            line_reg_next = 1'b0;
            ticks_left_next = pwfs_pkg::clamp_ticks(cfg.gap_low_ticks);
          end
          pwfs_pkg::PH_BIT_GAP: begin
            shift_word_next = shift_word >> 1;
            bits_left_next = bits_dec;
            line_reg_next = 1'b1;
            if (bits_dec == '0) begin
              phase_next = pwfs_pkg::PH_END_HIGH;
              ticks_left_next = pwfs_pkg::clamp_ticks(cfg.marker_high_ticks);
            end else begin
              // next bit is shift_word[1] before the shift lands
              phase_next = pwfs_pkg::PH_BIT_HIGH;
              ticks_left_next = pwfs_pkg::clamp_ticks(shift_word[1] ? cfg.one_high_ticks
                                                                    : cfg.zero_high_ticks);
            end
          end
          default: begin
            phase_next = pwfs_pkg::PH_IDLE;
            line_reg_next = 1'b0;
            ticks_left_next = '0;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.line_level = line_reg_next;
    res.busy_res = (phase_next != pwfs_pkg::PH_IDLE);
    res.frame_done = done;
    res.load_rejected = rejected;
    res.frame_word = frame_copy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pwfs_pkg::PH_IDLE;
      ticks_left <= '0;
      shift_word <= '0;
      frame_copy <= '0;
      bits_left <= '0;
      line_reg <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      ticks_left <= ticks_left_next;
      shift_word <= shift_word_next;
      frame_copy <= frame_copy_next;
      bits_left <= bits_left_next;
      line_reg <= line_reg_next;
    end
  end

endmodule

[hdl/pwfs_obuf.sv]
module pwfs_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pwfs_pkg::res_t din,
  output logic           room,
  pwfs_out_if.source     out
);

  logic out_valid, skid_valid;
  pwfs_pkg::res_t out_data, skid_data;
  logic take, out_free;

  assign take = out_valid && out.ready;
  assign out_free = !out_valid || take;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) skid_data <= din;
      end else if (push) begin
        out_data <= din;
      end
    end else if (push) begin
      skid_data <= din;
    end
  end

  assign out.valid = out_valid;
  assign out.line_level = out_data.line_level;
  assign out.busy_res = out_data.busy_res;
  assign out.frame_done = out_data.frame_done;
  assign out.load_rejected = out_data.load_rejected;
  assign out.frame_word = out_data.frame_word;

endmodule

[tb/tb_pulse_width_ir_frame_sender.sv]
`timescale 1ns / 100ps

module tb_pulse_width_ir_frame_sender;

  // Cycles with no word moving on either channel before the run is called hung.
  // Longest correct quiet stretch comes from random gaps/stalls and the short
  // settle before config writes, so this is many times over.
  localparam int WATCHDOG_LIMIT = 400;
  // Settle time after the last expected word.
  localparam int TAIL_CYCLES = 4;

  // Tracks the line, busy, done and reject flags plus the latched frame word,
  // one expected word per accepted item, and checks the result words in order.
  class frame_line_scoreboard;
    pwfs_pkg::cfg_t   regs;
    pwfs_pkg::phase_t phase;
    pwfs_pkg::tick_t  seg_left;
    logic [31:0]      data_sr;
    logic [31:0]      frame_latch;
    logic [5:0]       bits_to_go;
    logic             line_q;
    pwfs_pkg::res_t   line_words_due[$];
    int               mismatches;

    function new();
      regs.marker_high_ticks = 8'd16;
      regs.gap_low_ticks     = 8'd1;
      regs.zero_high_ticks   = 8'd2;
      regs.one_high_ticks    = 8'd8;
      phase       = pwfs_pkg::PH_IDLE;
      seg_left    = '0;
      data_sr     = '0;
      frame_latch = '0;
      bits_to_go  = '0;
      line_q      = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(pwfs_pkg::cfg_idx_t idx, pwfs_pkg::cfg_word_t val);
      case (idx)
        pwfs_pkg::REG_MARKER_HIGH: regs.marker_high_ticks = val;
        pwfs_pkg::REG_GAP_LOW:     regs.gap_low_ticks = val;
        pwfs_pkg::REG_ZERO_HIGH:   regs.zero_high_ticks = val;
        pwfs_pkg::REG_ONE_HIGH:    regs.one_high_ticks = val;
        default: ;
      endcase
    endfunction

    // Segment length in ticks: a zero register still lasts one tick.
    function pwfs_pkg::tick_t seg_ticks(pwfs_pkg::cfg_word_t val);
      if (val == '0) return pwfs_pkg::tick_t'(1);
      if (int'(val) > int'(pwfs_pkg::TICK_MAX)) return pwfs_pkg::TICK_MAX;
      return pwfs_pkg::tick_t'(val);
    endfunction

    // High mark of the next data bit, LSB first.
    function void arm_bit();
      phase    = pwfs_pkg::PH_BIT_HIGH;
      line_q   = 1'b1;
      seg_left = seg_ticks(data_sr[0] ? regs.one_high_ticks : regs.zero_high_ticks);
    endfunction

    function void note_item(logic func, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      pwfs_pkg::res_t w;
      logic done;
      logic rej;
      done = 1'b0;
      rej  = 1'b0;
      if (func == pwfs_pkg::FUNC_LOAD) begin
        if (phase != pwfs_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          frame_latch = {b0, b1, b2, b0 ^ b1 ^ b2};
          data_sr     = frame_latch;
          bits_to_go  = '0;
          phase       = pwfs_pkg::PH_START_HIGH;
          line_q      = 1'b1;
          seg_left    = seg_ticks(regs.marker_high_ticks);
        end
      end else if (phase != pwfs_pkg::PH_IDLE) begin
        seg_left = seg_left - 1'b1;
        if (seg_left == '0) begin
          case (phase)
            pwfs_pkg::PH_START_HIGH: begin
              phase    = pwfs_pkg::PH_START_GAP;
              line_q   = 1'b0;
              seg_left = seg_ticks(regs.gap_low_ticks);
            end
            pwfs_pkg::PH_START_GAP: begin
              bits_to_go = 6'(pwfs_pkg::FRAME_BITS);
              arm_bit();
            end
            pwfs_pkg::PH_BIT_HIGH: begin
              phase    = pwfs_pkg::PH_BIT_GAP;
              line_q   = 1'b0;
              seg_left = seg_ticks(regs.gap_low_ticks);
            end
            pwfs_pkg::PH_BIT_GAP: begin
              data_sr    = data_sr >> 1;
              bits_to_go = bits_to_go - 1'b1;
              if (bits_to_go == '0) begin
                phase    = pwfs_pkg::PH_END_HIGH;
                line_q   = 1'b1;
                seg_left = seg_ticks(regs.marker_high_ticks);
              end else begin
                arm_bit();
              end
            end
            default: begin
              phase    = pwfs_pkg::PH_IDLE;
              line_q   = 1'b0;
              seg_left = '0;
              done     = 1'b1;
            end
          endcase
        end
      end
      w.line_level    = line_q;
      w.busy_res      = (phase != pwfs_pkg::PH_IDLE);
      w.frame_done    = done;
      w.load_rejected = rej;
      w.frame_word    = frame_latch;
      line_words_due.push_back(w);
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void check_word(pwfs_pkg::res_t got);
      pwfs_pkg::res_t want;
      if (line_words_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, got %h", $time, got);
        return;
      end
      want = line_words_due.pop_front();
      cmp_field("line_level", 32'(want.line_level), 32'(got.line_level));
      cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      cmp_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
      cmp_field("load_rejected", 32'(want.load_rejected), 32'(got.load_rejected));
      cmp_field("frame_word", want.frame_word, got.frame_word);
    endfunction

    function int pending();
      return line_words_due.size();
    endfunction

    function bit busy();
      return phase != pwfs_pkg::PH_IDLE;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  pwfs_pkg::cfg_idx_t  cfg_index;
  pwfs_pkg::cfg_word_t cfg_data;

  pwfs_in_if  item_ch();
  pwfs_out_if result_ch();

  frame_line_scoreboard sb = new();

  // Stretches with no idling on either side.
  bit tx_calm;
  bit rx_calm;
  int stalled_cycles;

  pulse_width_ir_frame_sender dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hang detector: nothing accepted on either channel for too long.
  always @(posedge clk) begin
    if (rst) begin
      stalled_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_pulse_width_ir_frame_sender: errors");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Result side: random stall before taking each word,
  // sampled at the rising edge, ready moved at the falling edge.
  initial begin : result_sink
    int             stall;
    int             seen;
    pwfs_pkg::res_t got;
    result_ch.ready = 1'b0;
    seen = 0;
    rx_calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.line_level    = result_ch.line_level;
      got.busy_res      = result_ch.busy_res;
      got.frame_done    = result_ch.frame_done;
      got.load_rejected = result_ch.load_rejected;
      got.frame_word    = result_ch.frame_word;
      sb.check_word(got);
      seen++;
    end
  end

  // One item word: optional idle gap, then hold valid until accepted.
  task automatic send_word(input logic func, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid       <= 1'b1;
    item_ch.func        <= func;
    item_ch.first_byte  <= b0;
    item_ch.second_byte <= b1;
    item_ch.third_byte  <= b2;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(func, b0, b1, b2);
  endtask

  // Stop sending and let every expected word come back.
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Tick the current frame out to its end, then go quiet.
  task automatic finish_frame();
    while (sb.busy()) send_word(pwfs_pkg::FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
    settle();
  endtask

  task automatic write_reg(input pwfs_pkg::cfg_idx_t idx, input pwfs_pkg::cfg_word_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
  endtask

  // Block is idle here; four writes back to back, then drop the enable.
  task automatic write_cfg(input pwfs_pkg::cfg_word_t mark, input pwfs_pkg::cfg_word_t gap,
                           input pwfs_pkg::cfg_word_t zero_w,
                           input pwfs_pkg::cfg_word_t one_w);
    write_reg(pwfs_pkg::REG_MARKER_HIGH, mark);
    write_reg(pwfs_pkg::REG_GAP_LOW, gap);
    write_reg(pwfs_pkg::REG_ZERO_HIGH, zero_w);
    write_reg(pwfs_pkg::REG_ONE_HIGH, one_w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed: load when idle, ticks while sending, now and then
  // a load that lands mid-frame and must be rejected.
  task automatic run_random(input int count, input bit hold_mid);
    logic func;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (hold_mid && i == count / 2) settle();
      if (sb.busy()) begin
        func = ($urandom_range(0, 15) == 0) ? pwfs_pkg::FUNC_LOAD : pwfs_pkg::FUNC_TICK;
      end else begin
        func = ($urandom_range(0, 3) != 0) ? pwfs_pkg::FUNC_LOAD : pwfs_pkg::FUNC_TICK;
      end
      send_word(func, pick_byte(), pick_byte(), pick_byte());
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = pwfs_pkg::REG_MARKER_HIGH;
    cfg_data            = '0;
    item_ch.valid       = 1'b0;
    item_ch.func        = pwfs_pkg::FUNC_TICK;
    item_ch.first_byte  = '0;
    item_ch.second_byte = '0;
    item_ch.third_byte  = '0;
    tx_calm             = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset timing (16/1/2/8): tick while idle changes nothing,
    // load while idle starts the frame without counting as a tick, a load
    // mid-frame is rejected and leaves timing and frame word alone.
    send_word(pwfs_pkg::FUNC_TICK, 8'hFF, 8'hFF, 8'hFF);
    send_word(pwfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00);
    send_word(pwfs_pkg::FUNC_LOAD, 8'hFF, 8'h00, 8'hA5);
    send_word(pwfs_pkg::FUNC_LOAD, 8'h00, 8'hFF, 8'h5A);
    repeat (15) send_word(pwfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00);
    send_word(pwfs_pkg::FUNC_LOAD, 8'h12, 8'h34, 8'h56);
    repeat (3) send_word(pwfs_pkg::FUNC_TICK, 8'hFF, 8'hFF, 8'hFF);
    run_random(40, 1'b0);
    finish_frame();

    // Shortest legal segments; also holds off mid-stream until drained.
    write_cfg(8'd1, 8'd1, 8'd1, 8'd1);
    run_random(40, 1'b1);
    finish_frame();

    // All registers zero: every segment behaves as one tick.
    write_cfg(8'd0, 8'd0, 8'd0, 8'd0);
    run_random(20, 1'b0);
    finish_frame();

    write_cfg(8'd3, 8'd2, 8'd1, 8'd5);
    run_random(20, 1'b0);
    finish_frame();

    // Longest segments: the run may not get through the start mark and may end
    // mid-frame; all words are still checked.
    write_cfg(8'd255, 8'd255, 8'd255, 8'd255);
    run_random(262, 1'b0);
    settle();

    if (sb.mismatches == 0) begin
      $display("tb_pulse_width_ir_frame_sender: clean");
    end else begin
      $display("tb_pulse_width_ir_frame_sender: errors");
    end
    $finish;
  end

endmodule
